FILE: rtl/dual_controller_glcd_rect_writer_assert.svh
// Assertion macros for the dual-controller graphic display writer.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef DUAL_CONTROLLER_GLCD_RECT_WRITER_ASSERT_SVH
`define DUAL_CONTROLLER_GLCD_RECT_WRITER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DCG_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dcglcd: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define DCG_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dcglcd: next-cycle check failed");

`endif

FILE: rtl/dcglcd_pkg.sv
// Package for the dual-controller graphic display writer: geometry constants,
// command codes, transaction types and segment-bound helper. No dependencies.
`timescale 1ns / 1ps

package dcglcd_pkg;

   // Display geometry
   localparam int DISPLAY_COLUMNS    = 128;
   localparam int CONTROLLER_COLUMNS = 64;
   localparam int PAGE_COUNT         = 8;

   // Column bound arithmetic holds rect_x + rect_width and DISPLAY_COLUMNS
   localparam int BOUND_W = 9;

   // Controller instruction codes
   localparam logic [7:0] CMD_SETPAGE   = 8'hB8;
   localparam logic [7:0] CMD_SETCOL    = 8'h40;
   localparam logic [7:0] CMD_STARTLINE = 8'hC0;
   localparam logic [7:0] CMD_ON        = 8'h3F;
   localparam logic [7:0] COL_ADDR_MASK = 8'd63;

   // Chip select codes
   localparam logic [1:0] CS_LEFT  = 2'd1;
   localparam logic [1:0] CS_RIGHT = 2'd2;
   localparam logic [1:0] CS_BOTH  = 2'd3;

   typedef enum logic [1:0] {
      FUNC_FRAME = 2'd0,
      FUNC_RAW   = 2'd1,
      FUNC_INIT  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      CSR_RECT_X       = 3'd0,
      CSR_RECT_TOP     = 3'd1,
      CSR_RECT_WIDTH   = 3'd2,
      CSR_RECT_HEIGHT  = 3'd3,
      CSR_INVERT_MASK  = 3'd4,
      CSR_BACKLIGHT_ON = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       is_data;
      logic [1:0] chip_select;
      logic       backlight;
      logic       last;
      logic       rect_done;
   } rsp_type;

   typedef struct packed {
      logic [BOUND_W-1:0] lo;
      logic [BOUND_W-1:0] hi;
   } seg_type;

   // First column of a half
   function automatic logic [BOUND_W-1:0] half_base(input logic half);
      return half ? BOUND_W'(CONTROLLER_COLUMNS) : '0;
   endfunction

   // Column span of one half clipped to the rectangle and the display
   function automatic seg_type seg_bounds(input logic       half,
                                          input logic [6:0] x,
                                          input logic [7:0] w);
      logic [BOUND_W-1:0] base;
      logic [BOUND_W-1:0] s;
      logic [BOUND_W-1:0] e;
      seg_type            r;
      base = half_base(half);
      s    = BOUND_W'(x);
      e    = BOUND_W'(x) + BOUND_W'(w);
      if (s < base) s = base;
      if (e > base + BOUND_W'(CONTROLLER_COLUMNS)) e = base + BOUND_W'(CONTROLLER_COLUMNS);
      if (e > BOUND_W'(DISPLAY_COLUMNS)) e = BOUND_W'(DISPLAY_COLUMNS);
      r.lo = s;
      r.hi = e;
      return r;
   endfunction

endpackage

FILE: rtl/dual_controller_glcd_rect_writer.sv
// Top level of the dual-controller graphic display writer: turns frame bytes,
// raw commands and init requests into controller bus writes. Uses dcglcd_pkg.
`timescale 1ns / 1ps
`include "dual_controller_glcd_rect_writer_assert.svh"

// Channel  Direction  Handshake             Payload
// req      in         req_valid / req_stall  req_type: func, payload_byte
// rsp      out        rsp_valid / rsp_stall  rsp_type: one bus write
// csr      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// Each input transaction issues one bus write per cycle unless stalled: one for a
// frame byte inside an open segment or a raw command, two for init, three for a
// frame byte that opens a segment. The single output register sets that pace.
// A zero-write transaction (empty rectangle, unknown func) is dropped when
// accepted and holds nothing after its accept cycle.
// Reset is synchronous; traversal starts at the rectangle top afterwards.
// rsp_stall holds the output register and, through it, the input side.

module dual_controller_glcd_rect_writer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  dcglcd_pkg::req_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output dcglcd_pkg::rsp_type  rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [7:0]           csr_wdata
);
   import dcglcd_pkg::*;

   // Configuration registers
   logic [6:0] rect_x_ff;
   logic [5:0] rect_top_ff;
   logic [7:0] rect_width_ff;
   logic [6:0] rect_height_ff;
   logic [7:0] invert_mask_ff;
   logic       backlight_on_ff;

   // Traversal state; restart_ff makes the rectangle start take effect
   logic [2:0] page_ff,    page_in;
   logic       half_ff,    half_in;
   logic [7:0] column_ff,  column_in;
   logic       open_ff,    open_in;
   logic       restart_ff, restart_in;

   // Transaction in progress
   logic       cur_valid_ff, cur_valid_in;
   req_type    cur_ff;
   logic       step_ff,      step_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;

   // Geometry derived from configuration
   seg_type    seg0, seg1, seg_cur, seg_first;
   logic       used0, used1;
   logic [2:0] page_first;
   logic [7:0] row_end;
   logic [4:0] page_end_raw;
   logic [3:0] page_end;
   logic       rect_empty;

   // Effective traversal state
   logic [2:0] page_eff;
   logic       half_eff;
   logic [7:0] column_eff;
   logic       open_eff;

   logic       csr_write;
   logic       out_free;
   logic       fire;
   logic       req_accept;
   logic       produces;
   rsp_type    gen;
   logic [7:0] column_next;
   logic [BOUND_W-1:0] col_off;
   logic       half_next;
   seg_type    seg_next;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Segment bounds, page range and emptiness
   always_comb begin
      seg0         = seg_bounds(1'b0, rect_x_ff, rect_width_ff);
      seg1         = seg_bounds(1'b1, rect_x_ff, rect_width_ff);
      used0        = seg0.lo < seg0.hi;
      used1        = seg1.lo < seg1.hi;
      page_first   = rect_top_ff[5:3];
      row_end      = 8'(rect_top_ff) + 8'(rect_height_ff) + 8'd7;
      page_end_raw = row_end[7:3];
      page_end     = (page_end_raw > 5'(PAGE_COUNT)) ? 4'(PAGE_COUNT) : page_end_raw[3:0];
      rect_empty   = ({1'b0, page_first} >= page_end) || (!used0 && !used1);
      seg_first    = used0 ? seg0 : seg1;
   end

   // Pick restart values when a restart is pending
   always_comb begin
      page_eff   = restart_ff ? page_first : page_ff;
      half_eff   = restart_ff ? !used0 : half_ff;
      column_eff = restart_ff ? seg_first.lo[7:0] : column_ff;
      open_eff   = restart_ff ? 1'b0 : open_ff;
      seg_cur    = half_eff ? seg1 : seg0;
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = cur_valid_ff && out_free;

   // Build the next bus write and the traversal update
   always_comb begin
      gen         = '0;
      gen.backlight = backlight_on_ff;
      page_in     = page_ff;
      half_in     = half_ff;
      column_in   = column_ff;
      open_in     = open_ff;
      restart_in  = restart_ff;
      step_in     = step_ff;
      column_next = column_eff + 8'd1;
      col_off     = (seg_cur.lo - half_base(half_eff)) & BOUND_W'(COL_ADDR_MASK);
      half_next   = 1'b0;
      seg_next    = seg0;

      case (cur_ff.func)
         FUNC_RAW: begin
            gen.bus_byte    = cur_ff.payload_byte;
            gen.chip_select = CS_BOTH;
            gen.last        = 1'b1;
         end
         FUNC_INIT: begin
            gen.bus_byte    = step_ff ? CMD_STARTLINE : CMD_ON;
            gen.chip_select = CS_BOTH;
            gen.last        = step_ff;
            if (fire) step_in = 1'b1;
         end
         FUNC_FRAME: begin
            if (!open_eff && !step_ff) begin
               // set-page to both controllers
               gen.bus_byte    = CMD_SETPAGE | 8'(page_eff);
               gen.chip_select = CS_BOTH;
               if (fire) begin
                  page_in    = page_eff;
                  half_in    = half_eff;
                  column_in  = seg_cur.lo[7:0];
                  open_in    = 1'b0;
                  restart_in = 1'b0;
                  step_in    = 1'b1;
               end
            end else if (!open_eff) begin
               // set-column to the controller of this half
               gen.bus_byte    = CMD_SETCOL | col_off[7:0];
               gen.chip_select = half_eff ? CS_RIGHT : CS_LEFT;
               if (fire) open_in = 1'b1;
            end else begin
               // data write, then advance the traversal
               gen.bus_byte    = cur_ff.payload_byte ^ invert_mask_ff;
               gen.is_data     = 1'b1;
               gen.chip_select = half_eff ? CS_RIGHT : CS_LEFT;
               gen.last        = 1'b1;
               page_in         = page_eff;
               half_in         = half_eff;
               column_in       = column_next;
               open_in         = 1'b1;
               if ((BOUND_W'(column_next) >= seg_cur.hi) || (column_next == 8'd0)) begin
                  open_in = 1'b0;
                  if (!half_eff && used1) begin
                     half_next = 1'b1;
                     seg_next  = seg1;
                     half_in   = half_next;
                     column_in = seg_next.lo[7:0];
                  end else if (({1'b0, page_eff} + 4'd1) < page_end) begin
                     half_next = !used0;
                     seg_next  = used0 ? seg0 : seg1;
                     page_in   = page_eff + 3'd1;
                     half_in   = half_next;
                     column_in = seg_next.lo[7:0];
                  end else begin
                     gen.rect_done = 1'b1;
                  end
               end
               if (!fire) begin
                  page_in    = page_ff;
                  half_in    = half_ff;
                  column_in  = column_ff;
                  open_in    = open_ff;
               end else begin
                  restart_in = gen.rect_done;
               end
            end
         end
         default: begin
            gen.chip_select = CS_BOTH;
         end
      endcase

      // a configuration write restarts the traversal
      if (csr_write && (csr_index <= CSR_BACKLIGHT_ON)) restart_in = 1'b1;
   end

   // Accept a new transaction when nothing is pending or the last write leaves
   assign req_stall  = cur_valid_ff && !(fire && gen.last);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      case (req_data.func) inside
         FUNC_RAW, FUNC_INIT: produces = 1'b1;
         FUNC_FRAME:          produces = !rect_empty;
         default:             produces = 1'b0;
      endcase
      cur_valid_in = cur_valid_ff;
      if (fire && gen.last) cur_valid_in = 1'b0;
      if (req_accept) cur_valid_in = produces;
      rsp_valid_in = out_free ? fire : rsp_valid_ff;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         restart_ff   <= 1'b1;
         open_ff      <= 1'b0;
         step_ff      <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         restart_ff   <= restart_in;
         open_ff      <= open_in;
         step_ff      <= req_accept ? 1'b0 : step_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_ff       <= 7'd0;
         rect_top_ff     <= 6'd0;
         rect_width_ff   <= 8'd128;
         rect_height_ff  <= 7'd64;
         invert_mask_ff  <= 8'd0;
         backlight_on_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_RECT_X:       rect_x_ff       <= csr_wdata[6:0];
            CSR_RECT_TOP:     rect_top_ff     <= csr_wdata[5:0];
            CSR_RECT_WIDTH:   rect_width_ff   <= csr_wdata;
            CSR_RECT_HEIGHT:  rect_height_ff  <= csr_wdata[6:0];
            CSR_INVERT_MASK:  invert_mask_ff  <= csr_wdata;
            CSR_BACKLIGHT_ON: backlight_on_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Payload and traversal registers
   always_ff @(posedge clock) begin
      if (req_accept) cur_ff <= req_data;
      if (fire) rsp_ff <= gen;
      page_ff   <= page_in;
      half_ff   <= half_in;
      column_ff <= column_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `DCG_ASSERT_IMP(a_done_is_last, clock, reset, rsp_valid_ff && rsp_ff.rect_done, rsp_ff.last && rsp_ff.is_data)
   `DCG_ASSERT_IMP(a_data_one_chip, clock, reset, rsp_valid_ff && rsp_ff.is_data, rsp_ff.chip_select != CS_BOTH)
   `DCG_ASSERT_IMP(a_stall_needs_work, clock, reset, !cur_valid_ff, !req_stall)
   `DCG_ASSERT_NXT(a_csr_restarts, clock, reset, csr_write && (csr_index <= CSR_BACKLIGHT_ON), restart_ff)
   `DCG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_ff))

endmodule
